FILE: hdl/argsrt_pkg.sv
// ----------------------------------------------------------------------------
// argsrt_pkg
// Shared field widths and controller/datapath interface types for the
// argsort index sorter.
// ----------------------------------------------------------------------------
package argsrt_pkg;

    // fixed widths of the channel fields
    localparam int KEY_FIELD_BITS = 32;
    localparam int POS_FIELD_BITS = 6;

    // commands from controller to datapath
    typedef struct packed {
        logic load;        // input transfer this cycle
        logic scan_clear;  // restart the scan for the next rank
        logic scan_run;    // advance the running scan
        logic emit;        // move the best candidate into the output register
        logic col_clear;   // column finished, drop fill count and flags
    } argsrt_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic scan_done;   // every stored key compared for this rank
        logic out_free;    // output register can take a new result
        logic last_rank;   // the rank being found is the final one
    } argsrt_sts_t;

endpackage

FILE: hdl/argsrt_ctrl.sv
// ----------------------------------------------------------------------------
// argsrt_ctrl
// Controller: load phase, then one selection scan per output rank.
// ----------------------------------------------------------------------------
module argsrt_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_end_of_column,
    output logic                   s_ready,
    input  argsrt_pkg::argsrt_sts_t sts,
    output argsrt_pkg::argsrt_cmd_t cmd
);

    typedef enum logic {
        ST_LOAD,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                cmd.load = s_valid && ready_reg;
                if (s_valid && ready_reg && s_end_of_column) begin
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done && sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.last_rank) begin
                        cmd.col_clear = 1'b1;
                        state_next    = ST_LOAD;
                    end else begin
                        cmd.scan_clear = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_LOAD);
        end
    end

    assign s_ready = ready_reg;

endmodule

FILE: hdl/argsrt_datapath.sv
// ----------------------------------------------------------------------------
// argsrt_datapath
// Key memory, fill count, selection scan registers and output register.
// ----------------------------------------------------------------------------
module argsrt_datapath #(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 32
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic signed [argsrt_pkg::KEY_FIELD_BITS-1:0] s_key_value,
    input  argsrt_pkg::argsrt_cmd_t                    cmd,
    output argsrt_pkg::argsrt_sts_t                    sts,
    input  logic                                       m_ready,
    output logic                                       m_valid,
    output logic        [argsrt_pkg::POS_FIELD_BITS-1:0] m_source_position,
    output logic signed [argsrt_pkg::KEY_FIELD_BITS-1:0] m_sorted_key,
    output logic                                       m_final_rank,
    output logic                                       m_dropped_items
);

    localparam int IW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int EXT = (KEY_BITS > argsrt_pkg::KEY_FIELD_BITS) ?
                         KEY_BITS : argsrt_pkg::KEY_FIELD_BITS;

    logic [KEY_BITS-1:0] key_mem [DEPTH];

    logic [CW-1:0]       fill_reg;
    logic                overflow_reg;
    logic [CW-1:0]       idx_reg;
    logic                pend_reg;
    logic [IW-1:0]       cand_pos_reg;
    logic [KEY_BITS-1:0] rd_key_reg;
    logic [KEY_BITS-1:0] best_key_reg;
    logic [IW-1:0]       best_pos_reg;
    logic                best_found_reg;
    logic [KEY_BITS-1:0] last_key_reg;
    logic [IW-1:0]       last_pos_reg;
    logic                have_last_reg;
    logic [CW-1:0]       rank_reg;
    logic                m_valid_reg;
    logic [argsrt_pkg::POS_FIELD_BITS-1:0] out_pos_reg;
    logic [argsrt_pkg::KEY_FIELD_BITS-1:0] out_key_reg;
    logic                out_final_reg;
    logic                out_drop_reg;

    logic [EXT-1:0]      wide_in;
    logic [EXT-1:0]      wide_best;
    logic [KEY_BITS-1:0] in_key;
    logic                full;
    logic                stepping;
    logic                issue;
    logic                after_last;
    logic                better;
    logic                last_rank;

    // only the low key bits take part, zero-extended from the field
    assign wide_in   = EXT'($unsigned(s_key_value));
    assign in_key    = wide_in[KEY_BITS-1:0];
    assign wide_best = EXT'(best_key_reg);

    assign full      = (fill_reg == CW'(DEPTH));
    assign stepping  = cmd.scan_run && !cmd.scan_clear;
    assign issue     = stepping && (idx_reg != fill_reg);
    assign last_rank = ((rank_reg + CW'(1)) == fill_reg);

    // candidate must follow the last emitted (key, position) pair
    assign after_last = !have_last_reg
                     || ($signed(rd_key_reg) > $signed(last_key_reg))
                     || ((rd_key_reg == last_key_reg) && (cand_pos_reg > last_pos_reg));
    // positions come in ascending order, so ties keep the earlier one
    assign better     = !best_found_reg || ($signed(rd_key_reg) < $signed(best_key_reg));

    // key memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.load && !full) begin
            key_mem[fill_reg[IW-1:0]] <= in_key;
        end
        if (issue) begin
            rd_key_reg   <= key_mem[idx_reg[IW-1:0]];
            cand_pos_reg <= idx_reg[IW-1:0];
        end
    end

    // column bookkeeping and scan control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            overflow_reg   <= 1'b0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            best_found_reg <= 1'b0;
            have_last_reg  <= 1'b0;
            rank_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.load) begin
                if (full) begin
                    overflow_reg <= 1'b1;
                end else begin
                    fill_reg <= fill_reg + CW'(1);
                end
            end

            if (cmd.scan_clear) begin
                idx_reg        <= '0;
                pend_reg       <= 1'b0;
                best_found_reg <= 1'b0;
            end else if (cmd.scan_run) begin
                pend_reg <= issue;
                if (issue) begin
                    idx_reg <= idx_reg + CW'(1);
                end
                if (pend_reg && after_last && better) begin
                    best_found_reg <= 1'b1;
                end
            end

            if (cmd.emit) begin
                have_last_reg <= 1'b1;
                rank_reg      <= rank_reg + CW'(1);
            end
            if (cmd.col_clear) begin
                fill_reg      <= '0;
                overflow_reg  <= 1'b0;
                have_last_reg <= 1'b0;
                rank_reg      <= '0;
            end

            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (stepping && pend_reg && after_last && better) begin
            best_key_reg <= rd_key_reg;
            best_pos_reg <= cand_pos_reg;
        end
        if (cmd.emit) begin
            last_key_reg  <= best_key_reg;
            last_pos_reg  <= best_pos_reg;
            out_pos_reg   <= argsrt_pkg::POS_FIELD_BITS'(best_pos_reg);
            out_key_reg   <= wide_best[argsrt_pkg::KEY_FIELD_BITS-1:0];
            out_final_reg <= last_rank;
            out_drop_reg  <= overflow_reg;
        end
    end

    assign sts.scan_done = (idx_reg == fill_reg) && !pend_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.last_rank = last_rank;

    assign m_valid           = m_valid_reg;
    assign m_source_position = out_pos_reg;
    assign m_sorted_key      = out_key_reg;
    assign m_final_rank      = out_final_reg;
    assign m_dropped_items   = out_drop_reg;

    // fill count never passes capacity
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(DEPTH))
        else $error("fill count beyond capacity");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !cmd.emit)
        else $error("output register overwritten");

    // every emitted rank has found a candidate
    a_emit_found: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> best_found_reg)
        else $error("emit without candidate");

    // final rank empties the column
    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && last_rank) |=> (fill_reg == '0) && !overflow_reg)
        else $error("column not cleared after final rank");

endmodule

FILE: hdl/argsort_index_sorter_unit.sv
// ranks: after the item marking end of column, each rank takes one full scan of the n
//   stored keys, and a rank is emitted only once the output register is free
// throughput: one input transfer per cycle while loading; output is set by one
//   selection scan over the key memory per rank and by m_ready back-pressure
// reset: aresetn synchronous active low; clears fill count, overflow flag and handshake
//   state; the key memory is not cleared (only written entries are ever read)
// ----------------------------------------------------------------------------
// argsort_index_sorter_unit
// Stores one column of signed keys with their arrival positions and, at the
// end of the column, returns the positions in stable ascending key order.
// ----------------------------------------------------------------------------
module argsort_index_sorter_unit #(
    parameter int DEPTH    = 64,  // stored keys per column, 2 to 64
    parameter int KEY_BITS = 32   // compared key width, 8 to 64
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    // input channel: one key per transfer
    input  logic                                         s_valid,
    output logic                                         s_ready,
    input  logic signed [argsrt_pkg::KEY_FIELD_BITS-1:0] s_key_value,
    input  logic                                         s_end_of_column,
    // result channel: one rank per transfer
    output logic                                         m_valid,
    input  logic                                         m_ready,
    output logic        [argsrt_pkg::POS_FIELD_BITS-1:0] m_source_position,
    output logic signed [argsrt_pkg::KEY_FIELD_BITS-1:0] m_sorted_key,
    output logic                                         m_final_rank,
    output logic                                         m_dropped_items
);

    // command and status bundles between controller and datapath
    argsrt_pkg::argsrt_cmd_t cmd;
    argsrt_pkg::argsrt_sts_t sts;

    // controller: accepts keys in load phase; at end of column it runs one
    // scan per rank and hands each winner to the output register
    argsrt_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_end_of_column (s_end_of_column),
        .s_ready         (s_ready),
        .sts             (sts),
        .cmd             (cmd)
    );

    // datapath: key memory indexed by arrival position; each scan finds the
    // smallest (key, position) pair above the one emitted last, which gives
    // a stable order without moving any stored key
    argsrt_datapath #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_key_value       (s_key_value),
        .cmd               (cmd),
        .sts               (sts),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_source_position (m_source_position),
        .m_sorted_key      (m_sorted_key),
        .m_final_rank      (m_final_rank),
        .m_dropped_items   (m_dropped_items)
    );

endmodule
